FILE: design/fmdd_pkg.sv
// ----------------------------------------------------------------------------
// fmdd_pkg
// Shared types, constants and the arctangent table for the FM discriminator.
// ----------------------------------------------------------------------------
package fmdd_pkg;

  localparam int AngleStepsDef = 16;   // default CORDIC iteration count
  localparam int TabLen        = 24;   // entries in the arctangent table
  localparam int StepW         = 5;    // wide enough to index TabLen entries
  localparam int FracBits      = 24;   // fraction bits of the CORDIC x/y words
  localparam int ProdW         = 32;   // 16x16 signed product
  localparam int AccW          = 33;   // re/im of z * conj(z_prev)
  localparam int XyW           = 60;   // AccW + FracBits + growth guard
  localparam int ZW            = 34;   // angle, units of pi/2^31
  localparam int CfgIdxW       = 8;
  localparam int CfgDataW      = 8;

  localparam logic signed [ZW-1:0] PiUnits = ZW'(64'sd2147483648);

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgRotateEnable = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgDecimation   = CfgIdxW'(1);

  // products taken in order: cr*pr, cj*pj, cj*pr, cr*pj
  localparam logic [1:0] ProdCrPr = 2'd0;
  localparam logic [1:0] ProdCjPj = 2'd1;
  localparam logic [1:0] ProdCjPr = 2'd2;
  localparam logic [1:0] ProdCrPj = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_INIT,
    ST_ITER,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic             take;      // accept one pair, update sums
    logic             mul;       // register one product
    logic             acc;       // fold the product into re/im
    logic             init;      // load CORDIC x/y/z, roll sample history
    logic             iter;      // one CORDIC micro-rotation
    logic             load_out;  // scale angle into the output register
    logic [1:0]       prod_sel;
    logic [StepW-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic emit;      // pair being offered completes a decimated sample
    logic im_zero;   // imaginary part is zero: angle is 0 or pi directly
    logic out_free;  // output register can take a new beat
  } status_t;

  // atan(2^-i) in units of pi/2^31
  function automatic logic signed [ZW-1:0] atan_step(input logic [StepW-1:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:    v = 34'sd536870912;
      5'd1:    v = 34'sd316933406;
      5'd2:    v = 34'sd167458907;
      5'd3:    v = 34'sd85004756;
      5'd4:    v = 34'sd42667331;
      5'd5:    v = 34'sd21354465;
      5'd6:    v = 34'sd10679838;
      5'd7:    v = 34'sd5340245;
      5'd8:    v = 34'sd2670163;
      5'd9:    v = 34'sd1335087;
      5'd10:   v = 34'sd667544;
      5'd11:   v = 34'sd333772;
      5'd12:   v = 34'sd166886;
      5'd13:   v = 34'sd83443;
      5'd14:   v = 34'sd41722;
      5'd15:   v = 34'sd20861;
      5'd16:   v = 34'sd10430;
      5'd17:   v = 34'sd5215;
      5'd18:   v = 34'sd2608;
      5'd19:   v = 34'sd1304;
      5'd20:   v = 34'sd652;
      5'd21:   v = 34'sd326;
      5'd22:   v = 34'sd163;
      5'd23:   v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/fmdd_ctrl.sv
// ----------------------------------------------------------------------------
// fmdd_ctrl
// Sequencer: pair intake, four shared-multiplier products, CORDIC, output.
// ----------------------------------------------------------------------------
module fmdd_ctrl #(
  parameter int ANGLE_STEPS = fmdd_pkg::AngleStepsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fmdd_pkg::status_t status_i,
  output fmdd_pkg::cmd_t    cmd_o
);
  import fmdd_pkg::*;

  localparam logic [StepW-1:0] LastStep = StepW'(ANGLE_STEPS - 1);

  state_e           state_q, state_d;
  logic [1:0]       prod_q, prod_d;
  logic [StepW-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      prod_q  <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      prod_q  <= prod_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    prod_d         = prod_q;
    step_d         = step_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.prod_sel = prod_q;
    cmd_o.step     = step_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (status_i.emit) begin
            prod_d  = ProdCrPr;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (prod_q == ProdCrPj) begin
          state_d = ST_INIT;
        end else begin
          prod_d  = prod_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        step_d     = '0;
        state_d    = status_i.im_zero ? ST_FINISH : ST_ITER;
      end
      ST_ITER: begin
        cmd_o.iter = 1'b1;
        if (step_q == LastStep) begin
          state_d = ST_FINISH;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: design/fmdd_datapath.sv
// ----------------------------------------------------------------------------
// fmdd_datapath
// Rotation, integrate-and-dump sums, cross product, CORDIC and output beat.
// ----------------------------------------------------------------------------
module fmdd_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fmdd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [fmdd_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic [7:0]                       in_i_i,
  input  logic [7:0]                       in_q_i,
  input  fmdd_pkg::cmd_t                   cmd_i,
  output fmdd_pkg::status_t                status_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [15:0]               out_sample_o
);
  import fmdd_pkg::*;

  logic              rot_en_q;
  logic [7:0]        decim_q;
  logic [1:0]        phase_q;
  logic [7:0]        count_q;
  logic signed [15:0] sum_i_q, sum_q_q, last_i_q, last_q_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  re_q, im_q;
  logic signed [XyW-1:0]   x_q, y_q;
  logic signed [ZW-1:0]    z_q;
  logic              out_valid_q;
  logic signed [15:0] out_data_q;

  // ---- configuration and pair intake
  logic [7:0]        rot_i, rot_q, count_inc;
  logic signed [15:0] sum_i_d, sum_q_d;

  always_comb begin
    rot_i = in_i_i;
    rot_q = in_q_i;
    if (rot_en_q) begin
      unique case (phase_q)
        2'd1: begin rot_i = ~in_q_i; rot_q = in_i_i;  end
        2'd2: begin rot_i = ~in_i_i; rot_q = ~in_q_i; end
        2'd3: begin rot_i = in_q_i;  rot_q = ~in_i_i; end
        default: ;
      endcase
    end
  end

  assign sum_i_d   = sum_i_q + $signed({8'd0, rot_i}) - 16'sd127;
  assign sum_q_d   = sum_q_q + $signed({8'd0, rot_q}) - 16'sd127;
  assign count_inc = count_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_en_q <= 1'b0;
      decim_q  <= 8'd1;
      phase_q  <= '0;
      count_q  <= '0;
      sum_i_q  <= '0;
      sum_q_q  <= '0;
      last_i_q <= '0;
      last_q_q <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == CfgRotateEnable) rot_en_q <= cfg_data_i[0];
      if (cfg_we_i && cfg_index_i == CfgDecimation)   decim_q  <= cfg_data_i;
      if (cmd_i.take) begin
        phase_q <= phase_q + 2'd1;
        sum_i_q <= sum_i_d;
        sum_q_q <= sum_q_d;
        count_q <= status_o.emit ? 8'd0 : count_inc;
      end
      if (cmd_i.init) begin
        last_i_q <= sum_i_q;
        last_q_q <= sum_q_q;
        sum_i_q  <= '0;
        sum_q_q  <= '0;
      end
    end
  end

  // ---- cross product on one shared multiplier
  logic signed [15:0] mul_a, mul_b;
  logic signed [AccW-1:0] prod_ext;

  always_comb begin
    unique case (cmd_i.prod_sel)
      ProdCrPr: begin mul_a = sum_i_q; mul_b = last_i_q; end
      ProdCjPj: begin mul_a = sum_q_q; mul_b = last_q_q; end
      ProdCjPr: begin mul_a = sum_q_q; mul_b = last_i_q; end
      default:  begin mul_a = sum_i_q; mul_b = last_q_q; end
    endcase
  end

  assign prod_ext = AccW'(prod_q);

  // ---- CORDIC vectoring
  logic signed [XyW-1:0] re_w, im_w, xs, ys;
  logic signed [ZW-1:0]  atan_v;

  assign re_w   = XyW'(re_q) <<< FracBits;
  assign im_w   = XyW'(im_q) <<< FracBits;
  assign xs     = x_q >>> cmd_i.step;
  assign ys     = y_q >>> cmd_i.step;
  assign atan_v = atan_step(cmd_i.step);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
    if (cmd_i.acc) begin
      unique case (cmd_i.prod_sel)
        ProdCrPr: re_q <= prod_ext;
        ProdCjPj: re_q <= re_q + prod_ext;
        ProdCjPr: im_q <= prod_ext;
        default:  im_q <= im_q - prod_ext;
      endcase
    end
    if (cmd_i.init) begin
      priority if (im_q == '0) begin
        x_q <= re_w;
        y_q <= im_w;
        z_q <= re_q[AccW-1] ? PiUnits : '0;
      end else if (re_q[AccW-1]) begin
        // left half plane: flip by pi first
        x_q <= -re_w;
        y_q <= -im_w;
        z_q <= im_q[AccW-1] ? -PiUnits : PiUnits;
      end else begin
        x_q <= re_w;
        y_q <= im_w;
        z_q <= '0;
      end
    end
    if (cmd_i.iter) begin
      if (!y_q[XyW-1]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_v;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_v;
      end
    end
  end

  // ---- angle to audio: trunc(z * 32767 / 2^31), clamped
  localparam int ScW = ZW + 16;
  localparam int QuW = ScW - 31;
  logic signed [ScW-1:0] scaled, biased;
  logic signed [QuW-1:0] quo;
  logic signed [15:0]    sample;

  assign scaled = (ScW'(z_q) <<< 15) - ScW'(z_q);
  assign biased = scaled[ScW-1] ? scaled + ScW'(64'sd2147483647) : scaled;
  assign quo    = biased[ScW-1:31];

  always_comb begin
    priority if (quo > QuW'(32767))   sample = 16'sh7FFF;
    else if (quo < -QuW'(32768))      sample = 16'sh8000;
    else                              sample = quo[15:0];
  end

  // ---- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) out_data_q <= sample;
  end

  assign status_o.emit     = count_inc >= decim_q;
  assign status_o.im_zero  = im_q == '0;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_sample_o      = out_data_q;

endmodule

FILE: design/fm_iq_decimate_discriminate.sv
// ----------------------------------------------------------------------------
// fm_iq_decimate_discriminate
// FM quadrature discriminator with integrate-and-dump decimation.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one IQ pair per beat (offset-binary bytes). Pairs are
//   optionally turned by a 0/90/180/270 degree sequence, re-centered on 127
//   and summed; every `decimation` pairs the sum becomes one complex sample.
//   m_axis carries the phase step from the previous sample, pi -> 32767.
//   cfg: index 0 = rotate_enable, index 1 = decimation; write only while idle.
// Sequence:
//   A pair that does not close a sample is taken in ST_IDLE. A closing pair
//   is taken, then forms four products through one 16x16 multiplier (a
//   multiply and an accumulate state each), loads the CORDIC, runs
//   ANGLE_STEPS micro-rotations (one per cycle) and loads its m_axis beat.
//   An angle of exactly 0 or pi skips the CORDIC iterations.
// Reset clears sums, history, phase, count and config (decimation = 1).
// Stall: the result sits in an output register; new pairs are still taken
//   until the next closing pair, which waits in its last step for the slot.
// ----------------------------------------------------------------------------
module fm_iq_decimate_discriminate #(
  parameter int ANGLE_STEPS = fmdd_pkg::AngleStepsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fmdd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fmdd_pkg::CfgDataW-1:0] cfg_data_i,
  // input pairs
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // [7:0] in_i, [15:8] in_q
  // output samples
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata   // [15:0] audio_sample
);
  import fmdd_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic signed [15:0] sample;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = sample;

  fmdd_ctrl #(
    .ANGLE_STEPS (ANGLE_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fmdd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_i_i       (s_axis_tdata[7:0]),
    .in_q_i       (s_axis_tdata[15:8]),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (sample)
  );

endmodule

FILE: tb/sv/tb_fm_iq_decimate_discriminate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fm_iq_decimate_discriminate
// Self-checking bench for the FM IQ decimator / phase discriminator. A queue
// of IQ pairs feeds a falling-edge driver; a rising-edge monitor runs a local
// predictor (rotation, integrate-and-dump, CORDIC angle of z * conj(z_prev))
// on every accepted pair and matches each output beat against the oldest
// predicted audio sample. Register writes happen only while the block idles.
// ----------------------------------------------------------------------------
module tb_fm_iq_decimate_discriminate;

  localparam int     AngleSteps   = fmdd_pkg::AngleStepsDef;
  localparam int     SettleCycles = 40;     // extra idle wait at the end of settle()
  localparam int     StallLimit   = 4000;   // cycles with no beat on any channel
  localparam int     MaxReports   = 100;
  localparam int     ModeItems    = 600;    // random pairs per idling mode
  localparam int     CenterCode   = 127;
  localparam longint FullScale    = 64'sd32767;
  localparam longint HalfTurn     = 64'sd2147483648;  // pi in angle units
  localparam longint Prescale     = 64'sd16777216;    // 2^24 before CORDIC

  // stimulus styles
  localparam int StyleTone   = 0;  // rotating phasor, FM-like
  localparam int StyleNoise  = 1;  // uniform bytes
  localparam int StyleCorner = 2;  // 0 / 127 / 128 / 255 per byte
  localparam int StyleHold   = 3;  // one pair repeated

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [fmdd_pkg::CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [fmdd_pkg::CfgDataW-1:0] cfg_data_i    = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [15:0]                   s_axis_tdata  = '0;  // [7:0] in_i, [15:8] in_q
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [15:0]                   m_axis_tdata;        // [15:0] audio_sample

  fm_iq_decimate_discriminate #(
    .ANGLE_STEPS(AngleSteps)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the block's registers and history
  // ---------------------------------------------------------------------------
  logic               rot_on;
  logic [7:0]         decim;
  logic [1:0]         rot_phase;
  logic signed [15:0] sum_i, sum_q;
  logic signed [15:0] prev_i, prev_q;
  logic [7:0]         pairs_in_sum;

  // atan(2^-k) in units of pi/2^31
  longint arctan_units [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic [15:0]        pair_queue [$];      // pairs waiting for the driver
  logic signed [15:0] audio_expected [$];  // predicted audio samples, oldest first

  int  pairs_pushed   = 0;
  int  pairs_accepted = 0;
  int  errors         = 0;
  int  reports        = 0;
  int  stall_cycles   = 0;
  bit  pair_taken     = 1'b0;
  bit  cfg_taken      = 1'b0;
  int  send_idle_pct  = 37;
  int  recv_idle_pct  = 84;

  // stimulus generator state
  int          stim_style = StyleNoise;
  real         tone_phase = 0.0;
  real         tone_step  = 0.1;
  real         tone_amp   = 100.0;
  logic [15:0] held_pair  = '0;

  function automatic void reset_model();
    rot_on       = 1'b0;
    decim        = 8'd1;
    rot_phase    = '0;
    sum_i        = '0;
    sum_q        = '0;
    prev_i       = '0;
    prev_q       = '0;
    pairs_in_sum = '0;
  endfunction

  // Vectoring CORDIC; returns the angle of (x, y) in units of pi/2^31.
  function automatic longint phase_angle(longint x, longint y);
    longint acc_z, xs, ys;
    int     k;
    acc_z = 0;
    if (y == 0) return (x < 0) ? HalfTurn : 64'sd0;
    x = x * Prescale;
    y = y * Prescale;
    // left half-plane: pre-rotate by pi so the iterations converge
    if (x < 0) begin
      acc_z = (y > 0) ? HalfTurn : -HalfTurn;
      x     = -x;
      y     = -y;
    end
    for (k = 0; k < AngleSteps && k < 24; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (y >= 0) begin
        x     = x + ys;
        y     = y - xs;
        acc_z = acc_z + arctan_units[k];
      end else begin
        x     = x - ys;
        y     = y + xs;
        acc_z = acc_z - arctan_units[k];
      end
    end
    return acc_z;
  endfunction

  // One accepted pair: rotate, integrate, and on a closing pair predict a sample.
  function automatic void take_pair(logic [15:0] beat);
    logic [7:0] bi, bq, ri, rq;
    longint     cr, cj, pr, pj, re, im, ang, smp;
    bi = beat[7:0];
    bq = beat[15:8];
    ri = bi;
    rq = bq;
    if (rot_on) begin
      case (rot_phase)
        2'd1: begin
          ri = 8'hFF - bq;
          rq = bi;
        end
        2'd2: begin
          ri = 8'hFF - bi;
          rq = 8'hFF - bq;
        end
        2'd3: begin
          ri = bq;
          rq = 8'hFF - bi;
        end
        default: ;
      endcase
    end
    // phase steps on every pair, rotation on or off
    rot_phase    = rot_phase + 2'd1;
    sum_i        = 16'(int'(sum_i) + int'(ri) - CenterCode);
    sum_q        = 16'(int'(sum_q) + int'(rq) - CenterCode);
    pairs_in_sum = pairs_in_sum + 8'd1;
    // count at or above the register closes the sample (covers a lowered
    // register and decimation of zero)
    if (pairs_in_sum < decim) return;

    cr  = sum_i;
    cj  = sum_q;
    pr  = prev_i;
    pj  = prev_q;
    re  = cr * pr + cj * pj;
    im  = cj * pr - cr * pj;
    ang = (re == 0 && im == 0) ? 64'sd0 : phase_angle(re, im);
    smp = (ang * FullScale) / HalfTurn;  // truncates toward zero
    if (smp > FullScale) smp = FullScale;
    if (smp < -FullScale - 1) smp = -FullScale - 1;
    audio_expected.push_back(16'(smp));

    prev_i       = sum_i;
    prev_q       = sum_q;
    sum_i        = '0;
    sum_q        = '0;
    pairs_in_sum = '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] corner_byte();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd127;
      2:       return 8'd128;
      default: return 8'd255;
    endcase
  endfunction

  function automatic logic [15:0] next_pair();
    int vi, vq;
    case (stim_style)
      StyleTone: begin
        tone_phase = tone_phase + tone_step;
        vi = $rtoi(128.0 + tone_amp * $cos(tone_phase));
        vq = $rtoi(128.0 + tone_amp * $sin(tone_phase));
        return {vq[7:0], vi[7:0]};
      end
      StyleCorner: return {corner_byte(), corner_byte()};
      StyleHold:   return held_pair;
      default:     return 16'($urandom);
    endcase
  endfunction

  task automatic push_one(input logic [7:0] in_i, input logic [7:0] in_q);
    pair_queue.push_back({in_q, in_i});
    pairs_pushed++;
  endtask

  task automatic push_pairs(input int count);
    repeat (count) begin
      pair_queue.push_back(next_pair());
      pairs_pushed++;
    end
  endtask

  // sender holds off until every pair is in and every sample is out
  task automatic wait_results();
    while (pairs_accepted != pairs_pushed || audio_expected.size() != 0)
      @(negedge clk_i);
  endtask

  // wait for all results, then an extra idle stretch of SettleCycles
  task automatic settle();
    wait_results();
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [fmdd_pkg::CfgIdxW-1:0]  idx,
                           input logic [fmdd_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int pick_decimation();
    int r;
    r = $urandom_range(15);
    if (r == 0) return $urandom_range(255, 100);
    if (r == 1) return 0;
    if (r <= 4) return $urandom_range(40, 7);
    return $urandom_range(6, 1);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pairs and output backpressure change on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (!s_axis_tvalid || pair_taken) begin
      if (rst_ni && pair_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata  <= pair_queue.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: beats on all three channels are seen at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic signed [15:0] want;
    bit                 any_beat;
    pair_taken <= s_axis_tvalid && s_axis_tready;
    cfg_taken  <= cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      any_beat = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        any_beat = 1'b1;
        if (cfg_index_i == fmdd_pkg::CfgRotateEnable) rot_on = cfg_data_i[0];
        else if (cfg_index_i == fmdd_pkg::CfgDecimation) decim = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        any_beat = 1'b1;
        take_pair(s_axis_tdata);
        pairs_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        any_beat = 1'b1;
        if (audio_expected.size() == 0) begin
          errors++;
          if (reports++ < MaxReports)
            $error("audio_sample: no beat expected, got %0d", $signed(m_axis_tdata));
        end else begin
          want = audio_expected.pop_front();
          if (m_axis_tdata !== want) begin
            errors++;
            if (reports++ < MaxReports)
              $error("audio_sample: expected %0d, got %0d", want, $signed(m_axis_tdata));
          end
        end
      end
      stall_cycles = any_beat ? 0 : stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          dec, n, chunk, budget, setting;
    logic [6:0]  junk;
    logic        rot_bit;
    reset_model();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset settings (no rotation, decimation 1).
    push_one(8'd255, 8'd0);    // first sample: history is zero, product is zero
    push_one(8'd0,   8'd255);  // near-opposite phasor, angle close to pi
    push_one(8'd127, 8'd127);  // zero sum, zero product
    push_one(8'd200, 8'd127);  // previous sample zero again
    push_one(8'd54,  8'd127);  // exact reversal: negative real axis -> full scale
    push_one(8'd54,  8'd127);  // same sample twice: angle 0
    push_one(8'd127, 8'd255);  // quarter turn, negative direction
    push_one(8'd0,   8'd0);
    push_one(8'd255, 8'd255);
    push_one(8'd128, 8'd128);
    settle();

    // quarter-turn rotation on a constant input, all four phases
    write_reg(fmdd_pkg::CfgRotateEnable, 8'h01);
    repeat (4) push_one(8'd255, 8'd127);
    settle();

    // decimation of zero acts like one
    write_reg(fmdd_pkg::CfgDecimation, 8'd0);
    push_one(8'd255, 8'd0);
    push_one(8'd0,   8'd255);
    push_one(8'd128, 8'd127);
    settle();

    // register lowered below a partially filled sum: next pair closes it
    write_reg(fmdd_pkg::CfgDecimation, 8'd200);
    stim_style = StyleNoise;
    push_pairs(5);
    settle();
    write_reg(fmdd_pkg::CfgDecimation, 8'd3);
    push_pairs(3);

    // Random part: three idling modes, several register settings each.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      budget  = ModeItems;
      setting = 0;
      while (budget > 0) begin
        settle();
        junk       = 7'($urandom);
        rot_bit    = 1'($urandom);
        stim_style = $urandom_range(3);
        held_pair  = {corner_byte(), corner_byte()};
        tone_step  = (real'($urandom_range(2000)) - 1000.0) * 0.0032;
        tone_amp   = real'($urandom_range(127, 10));
        dec        = pick_decimation();
        if (setting == 0) begin
          // largest sums in modes 0 and 1: full-length integration of a held extreme pair
          if (mode < 2) begin
            dec        = 255;
            rot_bit    = 1'b0;
            stim_style = StyleHold;
            held_pair  = (mode == 0) ? 16'hFFFF : 16'h0000;
          end else begin
            dec = 1;
          end
        end
        write_reg(fmdd_pkg::CfgRotateEnable, {junk, rot_bit});
        write_reg(fmdd_pkg::CfgDecimation, 8'(dec));
        if (setting == 1)  // unmapped index must leave both registers alone
          write_reg(8'($urandom_range(255, 2)), 8'($urandom));
        n = (dec >= 100) ? $urandom_range(2 * dec, dec) : $urandom_range(80, 20);
        if (n > budget) n = budget;
        budget -= n;
        while (n > 0) begin
          chunk = $urandom_range(40, 1);
          if (chunk > n) chunk = n;
          push_pairs(chunk);
          n -= chunk;
          if ($urandom_range(3) == 0) wait_results();
        end
        setting++;
      end
    end

    settle();
    if (audio_expected.size() != 0) errors++;
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
